@@ rtl/core/tsts_pkg.sv @@
package tsts_pkg;

   localparam int unsigned TASK_SLOTS_DEFAULT = 64;
   localparam int unsigned SLOT_W = 6;
   localparam int unsigned PRIO_W = 6;
   localparam int unsigned CNT_W = 7;
   localparam int unsigned TICK_W = 32;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_SCHED = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [PRIO_W-1:0] PRIO_RESET = PRIO_W'(15);
   localparam logic [CNT_W-1:0] CNT_RESET_SLOT0 = CNT_W'(15);

   typedef struct packed {
      logic [1:0] opcode;
      logic user_mode;
      logic [SLOT_W-1:0] slot;
      logic slot_present;
      logic slot_runnable;
      logic [PRIO_W-1:0] slot_priority;
      logic [CNT_W-1:0] slot_counter;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] current_task;
      logic switched;
      logic [CNT_W-1:0] current_counter;
      logic [TICK_W-1:0] user_ticks;
      logic [TICK_W-1:0] system_ticks;
   } rsp_type;

   // one task slot travelling around the ring
   typedef struct packed {
      logic present;
      logic runnable;
      logic [PRIO_W-1:0] priority_val;
      logic [CNT_W-1:0] counter;
      logic [TICK_W-1:0] user_ticks;
      logic [TICK_W-1:0] system_ticks;
   } task_type;

   // ring control from the sequencer to every cell
   typedef struct packed {
      logic shift;
      logic recharge;
   } ring_ctl_type;

endpackage

@@ rtl/core/tsts_cell.sv @@
module tsts_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tsts_pkg::task_type    reset_val,
   input  tsts_pkg::ring_ctl_type ctl,
   input  logic                  recharge_en,
   input  tsts_pkg::task_type    prev,
   input  logic                  load,
   input  tsts_pkg::task_type    load_val,
   output tsts_pkg::task_type    cur
);
   import tsts_pkg::*;

   task_type slot_ff, slot_in;
   logic [CNT_W:0] sum;

   always_comb begin
      sum = {2'b00, prev.counter[CNT_W-1:1]} + {1'b0, prev.priority_val};
      slot_in = slot_ff;
      if (load) begin
         slot_in = load_val;
      end else if (ctl.shift) begin
         slot_in = prev;
         if (ctl.recharge && recharge_en && prev.present) begin
            slot_in.counter = sum[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= reset_val;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign cur = slot_ff;

endmodule

@@ rtl/core/tsts_ring.sv @@
module tsts_ring #(
   parameter int unsigned TASK_SLOTS = tsts_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tsts_pkg::ring_ctl_type ctl,
   input  logic                   recharge_en,
   input  logic                   load,
   input  tsts_pkg::task_type     load_val,
   output tsts_pkg::task_type     head
);
   import tsts_pkg::*;

   task_type links [TASK_SLOTS];
   task_type rst_other, rst_zero;

   always_comb begin
      rst_other = '0;
      rst_other.priority_val = PRIO_RESET;
      rst_zero = rst_other;
      rst_zero.present = 1'b1;
      rst_zero.runnable = 1'b1;
      rst_zero.counter = CNT_RESET_SLOT0;
   end

   // the head cell holds the slot addressed by the sequencer's position;
   // recharge the slot as it enters the head, once per rotation
   genvar g;
   generate
      for (g = 0; g < TASK_SLOTS; g++) begin : g_cell
         tsts_cell u_cell (
            .clock(clock),
            .reset(reset),
            .reset_val((g == 0) ? rst_zero : rst_other),
            .ctl(ctl),
            .recharge_en((g == 0) ? recharge_en : 1'b0),
            .prev(links[(g + 1) % TASK_SLOTS]),
            .load((g == 0) ? load : 1'b0),
            .load_val(load_val),
            .cur(links[g])
         );
      end
   endgenerate

   assign head = links[0];

endmodule

@@ rtl/core/time_slice_task_scheduler_unit.sv @@
// Channel | Direction | Payload  | Handshake
// req     | in        | req_type | req_valid / req_ready
// rsp     | out       | rsp_type | rsp_valid / rsp_ready
//
// Task slots sit in a ring of cells rotating one slot per cycle while the
// sequencer shifts; the head cell is the slot at position pos_ff.
// Tick: seek the running slot. Write: rotate to the slot and back. Scheduling
// pass: scan, then recharge and rescan if the best count is zero; seek home.
// Reset loads the table. One item is in work at a time, with an idle
// state after each result; a held result stalls acceptance until taken.
module time_slice_task_scheduler_unit #(
   parameter int unsigned TASK_SLOTS = tsts_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tsts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tsts_pkg::rsp_type rsp_data
);
   import tsts_pkg::*;

   localparam int unsigned PW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam logic [PW-1:0] LAST = PW'(TASK_SLOTS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEEK = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_RECH = 3'd3;
   localparam logic [2:0] ST_SCAN2 = 3'd4;
   localparam logic [2:0] ST_HOME = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] pos_nxt;
   logic [PW-1:0] run_ff, run_in;
   logic [PW-1:0] tgt_ff, tgt_in;
   logic [PW-1:0] pick_ff, pick_in;
   logic [CNT_W-1:0] best_ff, best_in;
   logic found_ff, found_in;
   logic cnt_done_ff, cnt_done_in;
   logic sw_ff, sw_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   ring_ctl_type ctl;
   logic load;
   task_type load_val, head;
   logic rech_en, elig;

   tsts_ring #(.TASK_SLOTS(TASK_SLOTS)) u_ring (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .recharge_en(rech_en),
      .load(load),
      .load_val(load_val),
      .head(head)
   );

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign pos_nxt = (pos_ff == LAST) ? '0 : pos_ff + 1'b1;

   // next slot entering the head is pos_nxt; recharge skips slot 0
   assign rech_en = (pos_ff != LAST);
   assign elig = head.present && head.runnable && (pos_ff != '0);

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      run_in = run_ff;
      tgt_in = tgt_ff;
      pick_in = pick_ff;
      best_in = best_ff;
      found_in = found_ff;
      cnt_done_in = cnt_done_ff;
      sw_in = sw_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl = '0;
      load = 1'b0;
      load_val = head;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               sw_in = 1'b0;
               found_in = 1'b0;
               best_in = '0;
               pick_in = '0;
               priority case (req_data.opcode)
                  OP_TICK: begin
                     tgt_in = run_ff;
                     state_in = ST_SEEK;
                  end
                  OP_WRITE: begin
                     if ({3'b000, req_data.slot} < 9'(TASK_SLOTS)) begin
                        tgt_in = PW'(req_data.slot);
                        state_in = ST_SEEK;
                     end else begin
                        tgt_in = run_ff;
                        state_in = ST_HOME;
                     end
                  end
                  OP_SCHED: begin
                     state_in = ST_SCAN;
                     cnt_done_in = 1'b0;
                  end
                  default: begin
                     tgt_in = run_ff;
                     state_in = ST_HOME;
                  end
               endcase
            end
         end
         ST_SEEK: begin
            if (pos_ff == tgt_ff) begin
               load = 1'b1;
               if (req_ff.opcode == OP_WRITE) begin
                  load_val.present = req_ff.slot_present;
                  load_val.runnable = req_ff.slot_runnable;
                  load_val.priority_val = req_ff.slot_priority;
                  load_val.counter = req_ff.slot_counter;
                  load_val.user_ticks = '0;
                  load_val.system_ticks = '0;
                  tgt_in = run_ff;
                  state_in = ST_HOME;
               end else begin
                  if (req_ff.user_mode) begin
                     load_val.user_ticks = head.user_ticks + 1'b1;
                  end else begin
                     load_val.system_ticks = head.system_ticks + 1'b1;
                  end
                  if (head.counter > CNT_W'(1)) begin
                     load_val.counter = head.counter - 1'b1;
                     tgt_in = run_ff;
                     state_in = ST_HOME;
                  end else begin
                     load_val.counter = '0;
                     if (req_ff.user_mode) begin
                        state_in = ST_SCAN;
                        cnt_done_in = 1'b0;
                     end else begin
                        tgt_in = run_ff;
                        state_in = ST_HOME;
                     end
                  end
               end
            end else begin
               ctl.shift = 1'b1;
               pos_in = pos_nxt;
            end
         end
         ST_SCAN, ST_SCAN2: begin
            // ascending order, >= : highest index wins ties
            if (elig && (!found_ff || head.counter >= best_ff)) begin
               found_in = 1'b1;
               best_in = head.counter;
               pick_in = pos_ff;
            end
            ctl.shift = 1'b1;
            pos_in = pos_nxt;
            if (pos_ff == LAST) begin
               cnt_done_in = 1'b1;
            end
            if (cnt_done_ff && pos_ff == LAST) begin
               if (state_ff == ST_SCAN && found_in && best_in == '0) begin
                  state_in = ST_RECH;
                  found_in = 1'b0;
                  pick_in = '0;
                  cnt_done_in = 1'b0;
               end else begin
                  sw_in = 1'b1;
                  run_in = found_in ? pick_in : '0;
                  tgt_in = found_in ? pick_in : '0;
                  state_in = ST_HOME;
               end
            end
         end
         ST_RECH: begin
            ctl.shift = 1'b1;
            ctl.recharge = 1'b1;
            pos_in = pos_nxt;
            if (pos_ff == LAST) begin
               state_in = ST_SCAN2;
               cnt_done_in = 1'b0;
            end
         end
         ST_HOME: begin
            if (pos_ff == tgt_ff) begin
               rsp_in.current_task = SLOT_W'(pos_ff);
               rsp_in.switched = sw_ff;
               rsp_in.current_counter = head.counter;
               rsp_in.user_ticks = head.user_ticks;
               rsp_in.system_ticks = head.system_ticks;
               rsp_valid_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               ctl.shift = 1'b1;
               pos_in = pos_nxt;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         run_ff <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         cnt_done_ff <= 1'b0;
         sw_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         run_ff <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff <= found_in;
         cnt_done_ff <= cnt_done_in;
         sw_ff <= sw_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff <= tgt_in;
      pick_ff <= pick_in;
      best_ff <= best_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp dropped while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken mid-operation");

   a_home_at_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_data.current_task == SLOT_W'(run_ff))
      else $error("result not from running slot");

   a_pass_switch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RECH) |=> (state_ff == ST_RECH || state_ff == ST_SCAN2))
      else $error("recharge left early");

endmodule
